### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file clkf_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/clkf_pkg.sv
// ----------------------------------------------------------------------------
// clkf_pkg
// Codes, segment tables and digit helpers for the clock face mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package clkf_pkg;

   localparam logic [2:0] MODE_SHOW_TIME   = 3'd0;
   localparam logic [2:0] MODE_SHOW_ALARM  = 3'd1;
   localparam logic [2:0] MODE_SET_HOUR    = 3'd2;
   localparam logic [2:0] MODE_SET_MINUTE  = 3'd3;
   localparam logic [2:0] MODE_SET_AL_HOUR = 3'd4;
   localparam logic [2:0] MODE_SET_AL_MIN  = 3'd5;

   localparam logic [2:0] INC_NONE     = 3'd0;
   localparam logic [2:0] INC_HOUR     = 3'd1;
   localparam logic [2:0] INC_MINUTE   = 3'd2;
   localparam logic [2:0] INC_AL_HOUR  = 3'd3;
   localparam logic [2:0] INC_AL_MIN   = 3'd4;

   localparam logic [1:0] CMD_NONE      = 2'd0;
   localparam logic [1:0] CMD_ALARM_ON  = 2'd1;
   localparam logic [1:0] CMD_ALARM_OFF = 2'd2;

   localparam int         PADDR_W        = 3;
   localparam int         PDATA_W        = 32;
   localparam logic       REG_ALARM_INIT = 1'b0;

   localparam logic [7:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [7:0] one;
      logic [7:0] two;
      logic [7:0] three;
      logic [7:0] four;
   } seg_type;

   // tens digit of a 6-bit value: multiply by 205/2048
   function automatic logic [3:0] digit_tens(input logic [5:0] v);
      logic [13:0] prod;
      prod = 14'(v) * 14'd205;
      return {1'b0, prod[13:11]};
   endfunction

   function automatic logic [3:0] digit_ones(input logic [5:0] v);
      logic [5:0] tens10;
      logic [5:0] diff;
      tens10 = 6'(digit_tens(v)) * 6'd10;
      diff   = v - tens10;
      return diff[3:0];
   endfunction

   function automatic logic [7:0] seg_hi(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h84;
         4'd1: s = 8'hCF;
         4'd2: s = 8'hA8;
         4'd3: s = 8'h89;
         4'd4: s = 8'hC3;
         4'd5: s = 8'h91;
         4'd6: s = 8'h90;
         4'd7: s = 8'h8F;
         4'd8: s = 8'h80;
         4'd9: s = 8'h81;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_third(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h82;
         4'd1: s = 8'hCF;
         4'd2: s = 8'hA1;
         4'd3: s = 8'h89;
         4'd4: s = 8'hCC;
         4'd5: s = 8'h98;
         4'd6: s = 8'h90;
         4'd7: s = 8'h8F;
         4'd8: s = 8'h80;
         4'd9: s = 8'h88;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_fourth(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h82;
         4'd1: s = 8'h9F;
         4'd2: s = 8'hA1;
         4'd3: s = 8'h89;
         4'd4: s = 8'h9C;
         4'd5: s = 8'hC8;
         4'd6: s = 8'hC0;
         4'd7: s = 8'h8F;
         4'd8: s = 8'h80;
         4'd9: s = 8'h88;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_mark(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h02;
         4'd1: s = 8'h1F;
         4'd2: s = 8'h21;
         4'd3: s = 8'h09;
         4'd4: s = 8'h1C;
         4'd5: s = 8'h48;
         4'd6: s = 8'h40;
         4'd7: s = 8'h0F;
         4'd8: s = 8'h00;
         4'd9: s = 8'h08;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/clkf_req_if.sv
// ----------------------------------------------------------------------------
// clkf_req_if
// Scan tick channel: button levels, alarm event, time and alarm time.
// ----------------------------------------------------------------------------
`default_nettype none

interface clkf_req_if;
   logic       valid;
   logic       ready;
   logic       select_pressed;
   logic       next_pressed;
   logic       alarm_interrupt;
   logic [4:0] time_hour;
   logic [5:0] time_minute;
   logic [4:0] alarm_hour;
   logic [5:0] alarm_minute;

   modport source (
      output valid, select_pressed, next_pressed, alarm_interrupt,
             time_hour, time_minute, alarm_hour, alarm_minute,
      input  ready
   );

   modport sink (
      input  valid, select_pressed, next_pressed, alarm_interrupt,
             time_hour, time_minute, alarm_hour, alarm_minute,
      output ready
   );
endinterface

`default_nettype wire

### rtl/clkf_rsp_if.sv
// ----------------------------------------------------------------------------
// clkf_rsp_if
// Result channel: mode, segment bytes, LED, buzzer and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

interface clkf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode_now;
   logic [7:0] segments_one;
   logic [7:0] segments_two;
   logic [7:0] segments_three;
   logic [7:0] segments_four;
   logic       led_on;
   logic       buzzer_on;
   logic [2:0] increment_request;
   logic       clear_alarm;
   logic [1:0] alarm_command;

   modport source (
      output valid, mode_now, segments_one, segments_two, segments_three,
             segments_four, led_on, buzzer_on, increment_request,
             clear_alarm, alarm_command,
      input  ready
   );

   modport sink (
      input  valid, mode_now, segments_one, segments_two, segments_three,
             segments_four, led_on, buzzer_on, increment_request,
             clear_alarm, alarm_command,
      output ready
   );

   modport monitor (
      input  valid, ready, mode_now, segments_one, segments_two, segments_three,
             segments_four, led_on, buzzer_on, increment_request,
             clear_alarm, alarm_command
   );
endinterface

`default_nettype wire

### rtl/clkf_display.sv
// ----------------------------------------------------------------------------
// clkf_display
// Segment bytes and LED level for a mode, alarm enable and clock values.
// ----------------------------------------------------------------------------
`default_nettype none

module clkf_display (
   input  logic                 [2:0] mode,
   input  logic                       alarm_en,
   input  logic                 [4:0] time_hour,
   input  logic                 [5:0] time_minute,
   input  logic                 [4:0] alarm_hour,
   input  logic                 [5:0] alarm_minute,
   output clkf_pkg::seg_type          segs,
   output logic                       led
);

   logic       use_time;
   logic [5:0] hour_val;
   logic [5:0] min_val;
   logic [3:0] hour_tens;
   logic [3:0] hour_ones;
   logic [3:0] min_tens;
   logic [3:0] min_ones;

   assign use_time  = (mode == clkf_pkg::MODE_SHOW_TIME) ||
                      (mode == clkf_pkg::MODE_SET_HOUR)  ||
                      (mode == clkf_pkg::MODE_SET_MINUTE);
   assign hour_val  = use_time ? {1'b0, time_hour} : {1'b0, alarm_hour};
   assign min_val   = use_time ? time_minute : alarm_minute;
   assign hour_tens = clkf_pkg::digit_tens(hour_val);
   assign hour_ones = clkf_pkg::digit_ones(hour_val);
   assign min_tens  = clkf_pkg::digit_tens(min_val);
   assign min_ones  = clkf_pkg::digit_ones(min_val);
   assign led       = (mode == clkf_pkg::MODE_SHOW_TIME);

   always_comb begin
      segs.one   = clkf_pkg::SEG_BLANK;
      segs.two   = clkf_pkg::SEG_BLANK;
      segs.three = clkf_pkg::SEG_BLANK;
      segs.four  = clkf_pkg::SEG_BLANK;
      case (mode)
         clkf_pkg::MODE_SHOW_TIME, clkf_pkg::MODE_SHOW_ALARM: begin
            segs.one   = clkf_pkg::seg_hi(hour_tens);
            segs.two   = clkf_pkg::seg_hi(hour_ones);
            segs.three = clkf_pkg::seg_third(min_tens);
            segs.four  = alarm_en ? clkf_pkg::seg_mark(min_ones)
                                  : clkf_pkg::seg_fourth(min_ones);
         end
         clkf_pkg::MODE_SET_HOUR, clkf_pkg::MODE_SET_AL_HOUR: begin
            segs.one = clkf_pkg::seg_hi(hour_tens);
            segs.two = clkf_pkg::seg_hi(hour_ones);
         end
         clkf_pkg::MODE_SET_MINUTE, clkf_pkg::MODE_SET_AL_MIN: begin
            segs.three = clkf_pkg::seg_third(min_tens);
            segs.four  = clkf_pkg::seg_fourth(min_ones);
         end
         default: begin
            segs.one = clkf_pkg::SEG_BLANK;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/clock_face_mode_controller.sv
// ----------------------------------------------------------------------------
// clock_face_mode_controller
// Mode, alarm and display control for a four-digit clock with two buttons.
// ----------------------------------------------------------------------------
//   req_chan carries one scan tick per transaction: both button levels, the
//   alarm event and the current and alarm times. rsp_chan returns exactly
//   one transaction per tick: mode, four segment bytes, LED, buzzer,
//   increment request, clear-alarm pulse and alarm on/off command.
//   An accepted tick is registered in the result register and shown on
//   rsp_chan in the next cycle. Throughput is one tick per cycle while
//   rsp_chan does not stall, set by the single result register;
//   req_chan.ready is high whenever that register is empty or is being taken in the same cycle.
//   If the receiver stalls, the result holds and one more tick cannot be
//   taken until it leaves.
//   The APB port holds the alarm start-up enable at addresses 0 to 3; a write
//   also loads the live alarm enable. Write only while no tick is pending.
//   Synchronous reset returns to show-time mode, stops ringing, clears the
//   buzzer, the start-up enable and the alarm enable, and empties the
//   result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_face_mode_controller (
   input  logic                                clock,
   input  logic                                reset,
   clkf_req_if.sink                            req_chan,
   clkf_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [clkf_pkg::PADDR_W-1:0]        paddr,
   input  logic [clkf_pkg::PDATA_W-1:0]        pwdata,
   output logic [clkf_pkg::PDATA_W-1:0]        prdata,
   output logic                                pready
);

   logic [2:0]        mode_reg_ff, mode_reg_in;
   logic              ringing_ff, ringing_in;
   logic              buzzer_ff, buzzer_in;
   logic              alarm_en_ff, alarm_en_in;
   logic              alarm_init_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_mode_ff;
   clkf_pkg::seg_type rsp_segs_ff;
   logic              rsp_led_ff;
   logic              rsp_buzzer_ff;
   logic [2:0]        rsp_inc_ff, inc_in;
   logic              rsp_clr_ff, clr_in;
   logic [1:0]        rsp_cmd_ff, cmd_in;

   clkf_pkg::seg_type segs;
   logic              led;
   logic              accept;
   logic              csr_write;
   logic              csr_hit;
   logic              ring_now;
   logic              pressed;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[clkf_pkg::PADDR_W-1] == clkf_pkg::REG_ALARM_INIT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? {{(clkf_pkg::PDATA_W-1){1'b0}}, alarm_init_ff}
                              : '0;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ring_now   = ringing_ff || req_chan.alarm_interrupt;
   assign pressed    = req_chan.select_pressed || req_chan.next_pressed;
   assign ringing_in = ring_now && !pressed;
   assign clr_in     = ring_now && pressed;
   assign buzzer_in  = ring_now ? !buzzer_ff : 1'b0;

   always_comb begin
      mode_reg_in = mode_reg_ff;
      inc_in      = clkf_pkg::INC_NONE;
      cmd_in      = clkf_pkg::CMD_NONE;
      alarm_en_in = alarm_en_ff;
      if (req_chan.next_pressed) begin
         case (mode_reg_ff)
            clkf_pkg::MODE_SHOW_TIME:   mode_reg_in = clkf_pkg::MODE_SHOW_ALARM;
            clkf_pkg::MODE_SHOW_ALARM:  mode_reg_in = clkf_pkg::MODE_SHOW_TIME;
            clkf_pkg::MODE_SET_HOUR:    inc_in      = clkf_pkg::INC_HOUR;
            clkf_pkg::MODE_SET_MINUTE:  inc_in      = clkf_pkg::INC_MINUTE;
            clkf_pkg::MODE_SET_AL_HOUR: inc_in      = clkf_pkg::INC_AL_HOUR;
            clkf_pkg::MODE_SET_AL_MIN:  inc_in      = clkf_pkg::INC_AL_MIN;
            default:                    mode_reg_in = mode_reg_ff;
         endcase
      end else if (req_chan.select_pressed) begin
         case (mode_reg_ff)
            clkf_pkg::MODE_SHOW_TIME:   mode_reg_in = clkf_pkg::MODE_SET_HOUR;
            clkf_pkg::MODE_SET_HOUR:    mode_reg_in = clkf_pkg::MODE_SET_MINUTE;
            clkf_pkg::MODE_SET_MINUTE:  mode_reg_in = clkf_pkg::MODE_SHOW_TIME;
            clkf_pkg::MODE_SHOW_ALARM:  mode_reg_in = clkf_pkg::MODE_SET_AL_HOUR;
            clkf_pkg::MODE_SET_AL_HOUR: mode_reg_in = clkf_pkg::MODE_SET_AL_MIN;
            clkf_pkg::MODE_SET_AL_MIN: begin
               mode_reg_in = clkf_pkg::MODE_SHOW_ALARM;
               cmd_in      = alarm_en_ff ? clkf_pkg::CMD_ALARM_OFF
                                         : clkf_pkg::CMD_ALARM_ON;
               alarm_en_in = !alarm_en_ff;
            end
            default:                    mode_reg_in = mode_reg_ff;
         endcase
      end
   end

   clkf_display u_display (
      .mode         (mode_reg_in),
      .alarm_en     (alarm_en_in),
      .time_hour    (req_chan.time_hour),
      .time_minute  (req_chan.time_minute),
      .alarm_hour   (req_chan.alarm_hour),
      .alarm_minute (req_chan.alarm_minute),
      .segs         (segs),
      .led          (led)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_reg_ff   <= clkf_pkg::MODE_SHOW_TIME;
         ringing_ff    <= 1'b0;
         buzzer_ff     <= 1'b0;
         alarm_en_ff   <= 1'b0;
         alarm_init_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            alarm_init_ff <= pwdata[0];
            alarm_en_ff   <= pwdata[0];
         end else if (accept) begin
            alarm_en_ff <= alarm_en_in;
         end
         if (accept) begin
            mode_reg_ff <= mode_reg_in;
            ringing_ff  <= ringing_in;
            buzzer_ff   <= buzzer_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff   <= mode_reg_in;
         rsp_segs_ff   <= segs;
         rsp_led_ff    <= led;
         rsp_buzzer_ff <= buzzer_in;
         rsp_inc_ff    <= inc_in;
         rsp_clr_ff    <= clr_in;
         rsp_cmd_ff    <= cmd_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.mode_now          = rsp_mode_ff;
   assign rsp_chan.segments_one      = rsp_segs_ff.one;
   assign rsp_chan.segments_two      = rsp_segs_ff.two;
   assign rsp_chan.segments_three    = rsp_segs_ff.three;
   assign rsp_chan.segments_four     = rsp_segs_ff.four;
   assign rsp_chan.led_on            = rsp_led_ff;
   assign rsp_chan.buzzer_on         = rsp_buzzer_ff;
   assign rsp_chan.increment_request = rsp_inc_ff;
   assign rsp_chan.clear_alarm       = rsp_clr_ff;
   assign rsp_chan.alarm_command     = rsp_cmd_ff;

endmodule

`default_nettype wire

### rtl/clkf_checker.sv
// ----------------------------------------------------------------------------
// clkf_checker
// Port-level checks on the result channel of the clock face controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clkf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_mode,
   input logic [7:0] rsp_seg_four,
   input logic       rsp_led,
   input logic [2:0] rsp_inc,
   input logic [1:0] rsp_cmd
);

   logic        rsp_stall;
   logic [10:0] rsp_watch;
   logic        show_time;
   logic        show_alarm;
   logic        set_mode;
   logic        has_cmd;
   logic        has_inc;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_watch  = {rsp_mode, rsp_seg_four};
   assign show_time  = (rsp_mode == clkf_pkg::MODE_SHOW_TIME);
   assign show_alarm = (rsp_mode == clkf_pkg::MODE_SHOW_ALARM);
   assign set_mode   = (rsp_mode == clkf_pkg::MODE_SET_HOUR)    ||
                       (rsp_mode == clkf_pkg::MODE_SET_MINUTE)  ||
                       (rsp_mode == clkf_pkg::MODE_SET_AL_HOUR) ||
                       (rsp_mode == clkf_pkg::MODE_SET_AL_MIN);
   assign has_cmd    = (rsp_cmd != clkf_pkg::CMD_NONE);
   assign has_inc    = (rsp_inc != clkf_pkg::INC_NONE);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_watch), "stalled transaction changed")
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "request not taken while empty")
   `ASSERT_CLK(a_led_mode, clock, reset, rsp_valid |-> (rsp_led == show_time), "LED disagrees with mode")
   `ASSERT_CLK(a_cmd_mode, clock, reset, rsp_valid && has_cmd |-> show_alarm && !has_inc, "misplaced alarm command")
   `ASSERT_CLK(a_inc_mode, clock, reset, rsp_valid && has_inc |-> set_mode, "increment outside a setting mode")

endmodule

bind clock_face_mode_controller clkf_checker u_clkf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_mode     (rsp_chan.mode_now),
   .rsp_seg_four (rsp_chan.segments_four),
   .rsp_led      (rsp_chan.led_on),
   .rsp_inc      (rsp_chan.increment_request),
   .rsp_cmd      (rsp_chan.alarm_command)
);

`default_nettype wire
